/* design/fcr_pkg.sv */
// Package for the framed command recognizer.
// Holds the command table, marker codes and shared types; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fcr_pkg;

    localparam int NUM_CMDS = 14;

    localparam logic [7:0] START_MARK = 8'h23;
    localparam logic [7:0] END_MARK   = 8'h21;
    localparam logic [3:0] NO_MATCH   = 4'd14;

    localparam logic [31:0] CMD_TABLE [NUM_CMDS] = '{
        32'h54696d65, 32'h4d6f6465, 32'h4d436f64, 32'h53436f64,
        32'h5353706b, 32'h53706c74, 32'h52656378, 32'h53746f70,
        32'h506c6179, 32'h44656c41, 32'h53746174, 32'h4361703f,
        32'h4c697374, 32'h44656c65
    };

    typedef logic [NUM_CMDS-1:0] match_vec_t;

    typedef struct packed {
        logic [3:0]  command_index;
        logic [31:0] command_code;
        logic [6:0]  frame_length;
        logic [7:0]  arg_first;
        logic [7:0]  arg_second;
        logic [7:0]  arg_third;
    } result_t;

endpackage
`default_nettype wire

/* design/fcr_if.sv */
// Valid/ready channel interfaces for the received bytes and the results.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface fcr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fcr_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  command_index;
    logic [31:0] command_code;
    logic [6:0]  frame_length;
    logic [7:0]  arg_first;
    logic [7:0]  arg_second;
    logic [7:0]  arg_third;

    modport source (output valid, output command_index, output command_code,
                    output frame_length, output arg_first, output arg_second,
                    output arg_third, input ready);
    modport sink   (input valid, input command_index, input command_code,
                    input frame_length, input arg_first, input arg_second,
                    input arg_third, output ready);
endinterface
`default_nettype wire

/* design/framed_command_recognizer.sv */
// A '!' result is registered in the output register, or in the skid entry while that waits.
// Throughput: one byte per cycle; a skid entry behind the output register keeps input
// flowing while one result waits, and a second waiting result stalls input until one is taken.
// Reset: rst_n clears frame count, byte chain, argument bytes and the output and skid valid flags.
// Top level of the framed command recognizer.
// Depends on fcr_pkg, fcr_if and fcr_byte_cell.
`timescale 1ns / 1ps
`default_nettype none
module framed_command_recognizer #(
    parameter int BUFFER_DEPTH = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fcr_in_if.sink     rx,
    fcr_out_if.source  cmd
);
    import fcr_pkg::*;

    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int EXT_W = (CNT_W > 7) ? CNT_W : 7;

    logic             accept;
    logic             is_start;
    logic             is_end;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] pos;
    logic [EXT_W-1:0] len_ext;
    logic [7:0]       arg_reg  [3];
    logic [7:0]       arg_next [3];

    logic [7:0]       chain [5];
    match_vec_t       lane_match [4];
    match_vec_t       hit;
    logic [3:0]       index;
    result_t          res;

    result_t          out_reg;
    result_t          out_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          skid_reg;
    result_t          skid_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    logic             out_fire;

    assign rx.ready = !skid_valid_reg;
    assign accept   = rx.valid && rx.ready;
    assign is_start = (rx.rx_byte == START_MARK);
    assign is_end   = (rx.rx_byte == END_MARK);

    // frame position
    always_comb
    begin
        pos = is_start ? '0 : count_reg;
        if (pos >= CNT_W'(BUFFER_DEPTH))
        begin
            pos = '0;
        end
        count_next = pos + CNT_W'(1);
        for (int k = 0; k < 3; k++)
        begin
            arg_next[k] = arg_reg[k];
            if (pos == CNT_W'(k + 1))
            begin
                arg_next[k] = rx.rx_byte;
            end
        end
    end

    assign len_ext = EXT_W'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int k = 0; k < 3; k++)
            begin
                arg_reg[k] <= 8'h00;
            end
        end
        else if (accept)
        begin
            count_reg <= count_next;
            for (int k = 0; k < 3; k++)
            begin
                arg_reg[k] <= arg_next[k];
            end
        end
    end

    // recent-byte chain, newest byte in lane 0
    assign chain[0] = rx.rx_byte;

    for (genvar g = 0; g < 4; g++)
    begin : g_cell
        fcr_byte_cell #(
            .LANE (g)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (accept),
            .clear ((g != 0) && is_start),
            .din   (chain[g]),
            .dout  (chain[g+1]),
            .match (lane_match[g])
        );
    end

    assign hit = lane_match[0] & lane_match[1] & lane_match[2] & lane_match[3];

    always_comb
    begin
        index = NO_MATCH;
        for (int i = NUM_CMDS - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                index = 4'(i);
            end
        end
    end

    always_comb
    begin
        res.command_index = index;
        res.command_code  = {chain[4], chain[3], chain[2], chain[1]};
        res.frame_length  = len_ext[6:0];
        res.arg_first     = arg_next[0];
        res.arg_second    = arg_next[1];
        res.arg_third     = arg_next[2];
    end

    // output register with skid entry
    assign out_fire = out_valid_reg && cmd.ready;

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_fire && skid_valid_reg)
        begin
            out_next        = skid_reg;
            skid_valid_next = 1'b0;
        end
        else if (accept && is_end)
        begin
            if (!out_valid_reg || cmd.ready)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign cmd.valid         = out_valid_reg;
    assign cmd.command_index = out_reg.command_index;
    assign cmd.command_code  = out_reg.command_code;
    assign cmd.frame_length  = out_reg.frame_length;
    assign cmd.arg_first     = out_reg.arg_first;
    assign cmd.arg_second    = out_reg.arg_second;
    assign cmd.arg_third     = out_reg.arg_third;

endmodule
`default_nettype wire

/* design/fcr_byte_cell.sv */
// One byte cell of the recent-byte shift chain, with its slice of the table compare.
// Depends on fcr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fcr_byte_cell #(
    parameter int LANE = 0
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              shift,
    input  wire logic              clear,
    input  wire logic [7:0]        din,
    output logic [7:0]             dout,
    output fcr_pkg::match_vec_t    match
);
    import fcr_pkg::*;

    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (shift)
        begin
            data_next = clear ? 8'h00 : din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= 8'h00;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_CMDS; i++)
        begin
            match[i] = (data_reg == CMD_TABLE[i][8*LANE +: 8]);
        end
    end

    assign dout = data_reg;

endmodule
`default_nettype wire

/* design/fcr_checker.sv */
// Port-level assertions for the framed command recognizer, bound to the top level.
// Depends on fcr_pkg and framed_command_recognizer.
`timescale 1ns / 1ps
`default_nettype none
module fcr_port_assert (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [7:0]  rx_byte,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [3:0]  command_index,
    input wire logic [31:0] command_code,
    input wire logic [6:0]  frame_length
);
    import fcr_pkg::*;

    logic in_acc;

    assign in_acc = in_valid && in_ready;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(command_code))
        else $error("stalled result changed");

    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (rx_byte == END_MARK) |=> out_valid)
        else $error("terminator produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !(in_acc && (rx_byte == END_MARK)) |=> !out_valid)
        else $error("result without terminator");

    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (command_index <= NO_MATCH) && (frame_length != 7'd0))
        else $error("result field out of range");

endmodule

bind framed_command_recognizer fcr_port_assert u_fcr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (rx.valid),
    .in_ready      (rx.ready),
    .rx_byte       (rx.rx_byte),
    .out_valid     (cmd.valid),
    .out_ready     (cmd.ready),
    .command_index (cmd.command_index),
    .command_code  (cmd.command_code),
    .frame_length  (cmd.frame_length)
);
`default_nettype wire
